// File: rtl/bit_addressable_register_map_unit_defines.svh
// assertion macros shared by the register map rtl
// depends on nothing; included by files that carry assertions
`ifndef BIT_ADDRESSABLE_REGISTER_MAP_UNIT_DEFINES_SVH
`define BIT_ADDRESSABLE_REGISTER_MAP_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BAMR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define BAMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/bamr_pkg.sv
// types and constants of the bit addressable register map
// depends on nothing
package bamr_pkg;

	localparam int NUM_REGS_DEF = 64;
	localparam int WORD_W       = 16;
	localparam int BIT_SEL_W    = 4;
	localparam int REG_IDX_W    = 8;
	localparam int BIT_ADDR_W   = 16;
	localparam int FLAGS_W      = 4;
	localparam int FUNC_W       = 3;
	localparam int NOTE_W       = 2;

	localparam logic [WORD_W-1:0] WORD_ALL_ONES = 16'hFFFF;

	// access flag positions
	localparam int FLAG_WORD_WRITE  = 0;
	localparam int FLAG_BIT_WRITE   = 1;
	localparam int FLAG_WORD_NOTIFY = 2;
	localparam int FLAG_BIT_NOTIFY  = 3;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_WRITE_WORD = 3'd0,
		FUNC_READ_WORD  = 3'd1,
		FUNC_SET_BIT    = 3'd2,
		FUNC_CLEAR_BIT  = 3'd3,
		FUNC_READ_BIT   = 3'd4,
		FUNC_GRANT      = 3'd5
	} func_t;

	typedef enum logic [NOTE_W-1:0] {
		NOTE_NONE = 2'd0,
		NOTE_WORD = 2'd1,
		NOTE_BIT  = 2'd2
	} note_t;

	// write port of the store
	typedef struct packed {
		logic                 we_word;
		logic                 we_flags;
		logic [REG_IDX_W-1:0] addr;
		logic [WORD_W-1:0]    word;
		logic [FLAGS_W-1:0]   flags;
	} store_wr_t;

	// registered read data of the store
	typedef struct packed {
		logic [WORD_W-1:0]  word;
		logic [FLAGS_W-1:0] flags;
	} store_rd_t;

endpackage

// File: rtl/bamr_if.sv
// request and response channel interfaces of the register map
// depends on bamr_pkg
interface bamr_req_if import bamr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [FUNC_W-1:0]     func;
	logic [REG_IDX_W-1:0]  reg_addr;
	logic [BIT_ADDR_W-1:0] bit_addr;
	logic [WORD_W-1:0]     write_value;
	logic [FLAGS_W-1:0]    grant_flags;

	modport source(output valid, func, reg_addr, bit_addr, write_value, grant_flags,
		input ready);
	modport sink(input valid, func, reg_addr, bit_addr, write_value, grant_flags,
		output ready);
endinterface

interface bamr_rsp_if import bamr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 status;
	logic [WORD_W-1:0]    read_data;
	logic [NOTE_W-1:0]    notify_kind;
	logic [REG_IDX_W-1:0] notify_reg;
	logic [WORD_W-1:0]    notify_mask;

	modport source(output valid, status, read_data, notify_kind, notify_reg, notify_mask,
		input ready);
	modport sink(input valid, status, read_data, notify_kind, notify_reg, notify_mask,
		output ready);
endinterface

// File: rtl/bamr_store.sv
// word and flag memories of the register map with per-entry valid bits
// depends on bamr_pkg
module bamr_store import bamr_pkg::*; #(
	parameter int NUM_REGS = NUM_REGS_DEF,
	parameter int AW       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  store_wr_t     wr,
	output store_rd_t     rd
);

	logic [WORD_W-1:0]  word_mem  [NUM_REGS];
	logic [FLAGS_W-1:0] flags_mem [NUM_REGS];
	logic [NUM_REGS-1:0] word_vld_q;
	logic [NUM_REGS-1:0] flags_vld_q;

	logic [WORD_W-1:0]  word_rd_q;
	logic [FLAGS_W-1:0] flags_rd_q;
	logic               word_rd_vld_q;
	logic               flags_rd_vld_q;

	logic [AW-1:0] wr_addr;
	assign wr_addr = wr.addr[AW-1:0];

	// memory write port
	always_ff @(posedge clk) begin
		if (wr.we_word) begin
			word_mem[wr_addr] <= wr.word;
		end
		if (wr.we_flags) begin
			flags_mem[wr_addr] <= wr.flags;
		end
	end

	// memory read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			word_rd_q  <= word_mem[rd_addr];
			flags_rd_q <= flags_mem[rd_addr];
		end
	end

	// valid bits stand in for the reset clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_vld_q     <= '0;
			flags_vld_q    <= '0;
			word_rd_vld_q  <= 1'b0;
			flags_rd_vld_q <= 1'b0;
		end else begin
			if (wr.we_word) begin
				word_vld_q[wr_addr] <= 1'b1;
			end
			if (wr.we_flags) begin
				flags_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				word_rd_vld_q  <= word_vld_q[rd_addr];
				flags_rd_vld_q <= flags_vld_q[rd_addr];
			end
		end
	end

	assign rd.word  = word_rd_vld_q  ? word_rd_q  : '0;
	assign rd.flags = flags_rd_vld_q ? flags_rd_q : '0;

endmodule

// File: rtl/bit_addressable_register_map_unit.sv
// top level of the bit addressable register map
// depends on bamr_pkg, bamr_if and bamr_store
//
// usage
//   req carries one request per transaction: word write, word read, bit set,
//   bit clear, bit read or a grant that ORs access flags into a register.
//   rsp returns exactly one result transaction per request, in order.
//   bit requests address register bit_addr[15:4], bit bit_addr[3:0].
// sequence
//   the accept cycle issues the memory read, the next cycle computes the
//   result and writes the entry back as it registers the result into the
//   response register. the block holds one request at a time: a new request
//   is taken only once stage 1 has passed its result on to the response
//   register.
// reset
//   arst_n clears the valid bits of both memories, so every register and
//   every flag set reads as zero; the response register empties.
// stall
//   a finished result waits in the response register; a new request is still
//   taken, but its result is held in place (no write back) until rsp frees.
`include "bit_addressable_register_map_unit_defines.svh"

module bit_addressable_register_map_unit import bamr_pkg::*; #(
	parameter int NUM_REGS = NUM_REGS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	bamr_req_if.sink   req,
	bamr_rsp_if.source rsp
);

	localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

	// request decode at accept
	logic                 req_acc;
	logic                 req_is_bit;
	logic                 req_ok;
	logic [REG_IDX_W-1:0] req_idx;

	// stage 1: request waiting for its read data
	logic                 busy_q;
	logic [FUNC_W-1:0]    func_s1;
	logic                 ok_s1;
	logic [REG_IDX_W-1:0] idx_s1;
	logic [BIT_SEL_W-1:0] bsel_s1;
	logic [WORD_W-1:0]    wval_s1;
	logic [FLAGS_W-1:0]   gflags_s1;

	// result compute
	store_wr_t            wr;
	store_rd_t            rd;
	logic                 fire;
	logic [WORD_W-1:0]    bmask;
	logic                 res_status;
	logic [WORD_W-1:0]    res_rdata;
	note_t                res_kind;
	logic [REG_IDX_W-1:0] res_reg;
	logic [WORD_W-1:0]    res_mask;
	logic                 we_word_c;
	logic                 we_flags_c;
	logic [WORD_W-1:0]    new_word_c;

	// response register
	logic                 out_vld_q;
	logic                 out_status_q;
	logic [WORD_W-1:0]    out_rdata_q;
	note_t                out_kind_q;
	logic [REG_IDX_W-1:0] out_reg_q;
	logic [WORD_W-1:0]    out_mask_q;

	assign req.ready = !busy_q;
	assign req_acc   = req.valid && req.ready;

	// bit operations pick the register from the bit address
	assign req_is_bit = (req.func == FUNC_SET_BIT) || (req.func == FUNC_CLEAR_BIT)
		|| (req.func == FUNC_READ_BIT);
	assign req_ok  = req_is_bit ? (req.bit_addr[BIT_ADDR_W-1:BIT_SEL_W] < 12'(NUM_REGS))
		: ({1'b0, req.reg_addr} < 9'(NUM_REGS));
	assign req_idx = req_is_bit ? req.bit_addr[BIT_SEL_W+REG_IDX_W-1:BIT_SEL_W] : req.reg_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req_acc) begin
			busy_q <= 1'b1;
		end else if (fire) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			func_s1   <= req.func;
			ok_s1     <= req_ok;
			idx_s1    <= req_idx;
			bsel_s1   <= req.bit_addr[BIT_SEL_W-1:0];
			wval_s1   <= req.write_value;
			gflags_s1 <= req.grant_flags;
		end
	end

	bamr_store #(
		.NUM_REGS(NUM_REGS),
		.AW      (AW)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (req_acc),
		.rd_addr(req_idx[AW-1:0]),
		.wr     (wr),
		.rd     (rd)
	);

	// a result leaves stage 1 once the response register can take it
	assign fire  = busy_q && (!out_vld_q || rsp.ready);
	assign bmask = WORD_W'(1) << bsel_s1;

	always_comb begin
		res_status = 1'b1;
		res_rdata  = '0;
		res_kind   = NOTE_NONE;
		res_reg    = '0;
		res_mask   = '0;
		we_word_c  = 1'b0;
		we_flags_c = 1'b0;
		new_word_c = wval_s1;
		unique case (func_s1)
			FUNC_WRITE_WORD: begin
				if (ok_s1 && rd.flags[FLAG_WORD_WRITE]) begin
					we_word_c  = 1'b1;
					res_status = 1'b0;
					if (rd.flags[FLAG_WORD_NOTIFY]) begin
						res_kind = NOTE_WORD;
						res_reg  = idx_s1;
					end
				end
			end
			FUNC_READ_WORD: begin
				if (ok_s1) begin
					res_status = 1'b0;
					res_rdata  = rd.word;
				end else begin
					res_rdata = WORD_ALL_ONES;
				end
			end
			FUNC_SET_BIT, FUNC_CLEAR_BIT: begin
				new_word_c = (func_s1 == FUNC_SET_BIT) ? (rd.word | bmask) : (rd.word & ~bmask);
				if (ok_s1 && rd.flags[FLAG_BIT_WRITE]) begin
					we_word_c  = 1'b1;
					res_status = 1'b0;
					// bit notify wins over word notify
					if (rd.flags[FLAG_BIT_NOTIFY]) begin
						res_kind = NOTE_BIT;
						res_reg  = idx_s1;
						res_mask = bmask;
					end else if (rd.flags[FLAG_WORD_NOTIFY]) begin
						res_kind = NOTE_WORD;
						res_reg  = idx_s1;
					end
				end
			end
			FUNC_READ_BIT: begin
				if (ok_s1) begin
					res_status = 1'b0;
					res_rdata  = {{(WORD_W-1){1'b0}}, |(rd.word & bmask)};
				end else begin
					res_rdata = WORD_W'(1);
				end
			end
			FUNC_GRANT: begin
				if (ok_s1) begin
					we_flags_c = 1'b1;
					res_status = 1'b0;
				end
			end
			default: begin
				// unknown function: error, nothing changes
			end
		endcase
	end

	// write back in the compute cycle; no read can overlap it
	assign wr.we_word  = fire && we_word_c;
	assign wr.we_flags = fire && we_flags_c;
	assign wr.addr     = idx_s1;
	assign wr.word     = new_word_c;
	assign wr.flags    = rd.flags | gflags_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fire) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_status_q <= res_status;
			out_rdata_q  <= res_rdata;
			out_kind_q   <= res_kind;
			out_reg_q    <= res_reg;
			out_mask_q   <= res_mask;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.status      = out_status_q;
	assign rsp.read_data   = out_rdata_q;
	assign rsp.notify_kind = out_kind_q;
	assign rsp.notify_reg  = out_reg_q;
	assign rsp.notify_mask = out_mask_q;

	// an accepted request occupies stage 1 in the next cycle
	`BAMR_ASSERT_NEXT(a_acc_busy, clk, arst_n, req_acc, busy_q)
	// a new result only ever comes from a busy stage 1
	`BAMR_ASSERT_NOW(a_rsp_from_busy, clk, arst_n, $rose(out_vld_q), $past(busy_q))
	// a bit notify carries exactly one mask bit
	`BAMR_ASSERT_NOW(a_bit_mask, clk, arst_n, rsp.valid && (rsp.notify_kind == NOTE_BIT),
		$onehot(rsp.notify_mask))
	// an error never carries a notify
	`BAMR_ASSERT_NOW(a_err_quiet, clk, arst_n, rsp.valid && rsp.status,
		rsp.notify_kind == NOTE_NONE)

endmodule
